// File: sv/mdp_pkg.sv
`default_nettype none
package mdp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FIELD = 2'd1,
        PH_ELEM  = 2'd2,
        PH_NAME  = 2'd3
    } phase_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_OPEN     = 3'd1;
    localparam logic [2:0] ST_BAD_PARAM   = 3'd2;
    localparam logic [2:0] ST_BAD_RETURN  = 3'd3;
    localparam logic [2:0] ST_NAME_LONG   = 3'd4;

    localparam logic [3:0] KIND_VOID = 4'd0;
    localparam logic [3:0] KIND_B    = 4'd1;
    localparam logic [3:0] KIND_C    = 4'd2;
    localparam logic [3:0] KIND_D    = 4'd3;
    localparam logic [3:0] KIND_F    = 4'd4;
    localparam logic [3:0] KIND_I    = 4'd5;
    localparam logic [3:0] KIND_J    = 4'd6;
    localparam logic [3:0] KIND_S    = 4'd7;
    localparam logic [3:0] KIND_Z    = 4'd8;
    localparam logic [3:0] KIND_REF  = 4'd9;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_ARRAY  = 8'h5B;

    localparam logic [1:0] REG_WIDE_SLOT   = 2'd0;
    localparam logic [1:0] REG_NARROW_SLOT = 2'd1;
    localparam logic [1:0] REG_REF_SLOT    = 2'd2;
    localparam logic [1:0] REG_MAX_NAME    = 2'd3;

    localparam logic [9:0] SLOT_MAX = 10'd1023;
    localparam logic [9:0] NAME_MAX = 10'd1023;
    localparam logic [7:0] DIM_MAX  = 8'd255;

    typedef struct packed {
        logic [1:0] wide_slot_words;
        logic [1:0] narrow_slot_words;
        logic [1:0] ref_slot_words;
        logic [9:0] max_name_len;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic       in_return;
        logic [7:0] param_tally;
        logic [9:0] slot_tally;
        logic [7:0] dim_tally;
        logic [9:0] name_length;
    } state_t;

    typedef struct packed {
        logic [7:0] return_dims;
        logic [3:0] return_kind;
        logic       returns_value;
        logic [9:0] param_slots;
        logic [7:0] param_count;
        logic [2:0] status;
    } result_t;

    function automatic logic [3:0] base_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            8'h42: k = KIND_B;
            8'h43: k = KIND_C;
            8'h44: k = KIND_D;
            8'h46: k = KIND_F;
            8'h49: k = KIND_I;
            8'h4A: k = KIND_J;
            8'h53: k = KIND_S;
            8'h5A: k = KIND_Z;
            default: k = KIND_VOID;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// File: sv/mdp_step.sv
`default_nettype none
module mdp_step import mdp_pkg::*; #(
    parameter logic [7:0] PARAM_CAP = 8'd255
) (
    input  wire state_t     cur,
    input  wire cfg_t       cfg,
    input  wire logic [7:0] char_in,
    input  wire logic       first,
    output state_t          nxt,
    output logic            emit,
    output result_t         res
);

    logic       start_field;
    logic       fld_done;
    logic       fail;
    logic [3:0] fkind;
    logic [3:0] bk;
    logic [1:0] w;
    logic [10:0] slot_sum;
    logic [2:0] st;
    logic       rv;
    logic [3:0] kind;
    logic [7:0] dims;

    assign bk = base_kind(char_in);

    always_comb begin
        nxt         = cur;
        emit        = 1'b0;
        start_field = 1'b0;
        fld_done    = 1'b0;
        fail        = 1'b0;
        fkind       = KIND_VOID;
        w           = 2'd0;
        slot_sum    = 11'd0;
        st          = ST_OK;
        rv          = 1'b0;
        kind        = KIND_VOID;
        dims        = 8'd0;

        if (first) begin
            nxt.in_return   = 1'b0;
            nxt.param_tally = 8'd0;
            nxt.slot_tally  = 10'd0;
            nxt.dim_tally   = 8'd0;
            nxt.name_length = 10'd0;
            if (char_in != CH_OPEN) begin
                emit = 1'b1;
                st   = ST_NO_OPEN;
            end else begin
                nxt.phase = PH_FIELD;
            end
        end else begin
            case (cur.phase)
                PH_FIELD: begin
                    if (char_in == CH_NUL) begin
                        fail = 1'b1;
                    end else if (cur.in_return) begin
                        if (char_in == CH_V) begin
                            emit = 1'b1;
                        end else begin
                            start_field = 1'b1;
                        end
                    end else if (char_in == CH_CLOSE) begin
                        nxt.in_return = 1'b1;
                        nxt.dim_tally = 8'd0;
                    end else begin
                        if (cur.param_tally < PARAM_CAP) begin
                            nxt.param_tally = cur.param_tally + 8'd1;
                        end
                        start_field = 1'b1;
                    end
                end
                PH_ELEM: begin
                    if (char_in == CH_NUL) begin
                        fail = 1'b1;
                    end else begin
                        start_field = 1'b1;
                    end
                end
                PH_NAME: begin
                    if (cur.name_length < NAME_MAX) begin
                        nxt.name_length = cur.name_length + 10'd1;
                    end
                    if (char_in == CH_SEMI) begin
                        if (nxt.name_length == 10'd1) begin
                            fail = 1'b1;
                        end else begin
                            fld_done = 1'b1;
                            fkind    = KIND_REF;
                        end
                    end else if (char_in == CH_NUL) begin
                        fail = 1'b1;
                    end else if (nxt.name_length >= cfg.max_name_len) begin
                        emit = 1'b1;
                        st   = ST_NAME_LONG;
                    end
                end
                default: begin
                end
            endcase
        end

        if (start_field) begin
            if (bk != KIND_VOID) begin
                fld_done = 1'b1;
                fkind    = bk;
            end else if (char_in == CH_L) begin
                nxt.name_length = 10'd0;
                nxt.phase       = PH_NAME;
            end else if (char_in == CH_ARRAY) begin
                if (cur.dim_tally < DIM_MAX) begin
                    nxt.dim_tally = cur.dim_tally + 8'd1;
                end
                nxt.phase = PH_ELEM;
            end else begin
                fail = 1'b1;
            end
        end

        if (fld_done) begin
            if (cur.in_return) begin
                emit = 1'b1;
                rv   = 1'b1;
                kind = fkind;
                dims = cur.dim_tally;
            end else begin
                if (cur.dim_tally != 8'd0 || fkind == KIND_REF) begin
                    w = cfg.ref_slot_words;
                end else if (fkind == KIND_D || fkind == KIND_J) begin
                    w = cfg.wide_slot_words;
                end else begin
                    w = cfg.narrow_slot_words;
                end
                slot_sum = {1'b0, cur.slot_tally} + {9'd0, w};
                nxt.slot_tally = (slot_sum > {1'b0, SLOT_MAX}) ? SLOT_MAX : slot_sum[9:0];
                nxt.dim_tally  = 8'd0;
                nxt.phase      = PH_FIELD;
            end
        end

        if (fail) begin
            emit = 1'b1;
            st   = cur.in_return ? ST_BAD_RETURN : ST_BAD_PARAM;
        end

        if (emit) begin
            nxt.phase = PH_IDLE;
        end

        res.status        = st;
        res.param_count   = nxt.param_tally;
        res.param_slots   = (st == ST_OK) ? nxt.slot_tally : 10'd0;
        res.returns_value = (st == ST_OK) ? rv : 1'b0;
        res.return_kind   = (st == ST_OK) ? kind : KIND_VOID;
        res.return_dims   = (st == ST_OK) ? dims : 8'd0;
    end

endmodule
`default_nettype wire

// File: sv/method_descriptor_parser.sv
// method descriptor parser
// s_axis carries one descriptor byte per item: tdata is the byte, tuser set
// marks the first byte of a new descriptor. every byte is checked against the
// descriptor grammar and the parameter count and slot total are kept running.
// m_axis gives one item when a descriptor ends, either on its return type or
// on the first error; bytes outside an open descriptor give nothing.
// the result item is registered and appears in the cycle after the accepted
// byte; one byte is taken every cycle while s_axis_tready is high, set by the
// single state update between the state registers and the result register.
// the result register doubles as the output stage: s_axis_tready stays high
// while it is empty or being drained, so a stalled receiver holds the input
// only when a result is actually waiting.
// reset (synchronous, active low) returns the parser to idle, drops any
// pending result and loads the default slot widths and name length limit.
// the apb port sets the slot widths and name limit; write only while idle.
`default_nettype none
module method_descriptor_parser import mdp_pkg::*; #(
    parameter int MAX_PARAMS = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_in[7:0]
    input  wire logic        s_axis_tuser,   // first
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[2:0], param_count[10:3], param_slots[20:11], returns_value[21],
    // return_kind[25:22], return_dims[33:26], zero[39:34]
    output logic [39:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [7:0] PARAM_CAP = 8'((MAX_PARAMS < 255) ? MAX_PARAMS : 255);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    logic    emit;
    result_t res;
    result_t res_reg;
    logic    m_valid_reg;
    logic    s_accept;
    logic    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        case (paddr[3:2])
            REG_WIDE_SLOT:   prdata = {30'd0, cfg_reg.wide_slot_words};
            REG_NARROW_SLOT: prdata = {30'd0, cfg_reg.narrow_slot_words};
            REG_REF_SLOT:    prdata = {30'd0, cfg_reg.ref_slot_words};
            REG_MAX_NAME:    prdata = {22'd0, cfg_reg.max_name_len};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wide_slot_words   <= 2'd2;
            cfg_reg.narrow_slot_words <= 2'd1;
            cfg_reg.ref_slot_words    <= 2'd1;
            cfg_reg.max_name_len      <= 10'd255;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_WIDE_SLOT:   cfg_reg.wide_slot_words   <= pwdata[1:0];
                REG_NARROW_SLOT: cfg_reg.narrow_slot_words <= pwdata[1:0];
                REG_REF_SLOT:    cfg_reg.ref_slot_words    <= pwdata[1:0];
                REG_MAX_NAME:    cfg_reg.max_name_len      <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    mdp_step #(
        .PARAM_CAP (PARAM_CAP)
    ) u_step (
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .char_in (s_axis_tdata),
        .first   (s_axis_tuser),
        .nxt     (state_next),
        .emit    (emit),
        .res     (res)
    );

    assign s_axis_tready = ~m_valid_reg | m_axis_tready;
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_IDLE, default: '0};
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, res_reg};

endmodule
`default_nettype wire
